FILE: rtl/core/bfs_pkg.sv
// Shared types and constants of the bitmap first-set/first-clear scanner.
`timescale 1ns / 1ps
package bfs_pkg;

  localparam int FUNC_W  = 2;
  localparam int INDEX_W = 6;
  localparam int DATA_W  = 64;
  localparam int START_W = 12;
  localparam int LEN_W   = 13;
  localparam int POS_W   = 12;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE      = 2'd0,
    FUNC_SCAN_SET   = 2'd1,
    FUNC_SCAN_CLEAR = 2'd2,
    FUNC_NOP        = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic write;
    logic load;
    logic div_step;
    logic setup;
    logic scan;
    logic publish;
  } scan_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic empty;
    logic div_done;
    logic hit;
    logic last_word;
  } scan_sts_t;

endpackage

FILE: rtl/core/bitmap_first_set_or_clear_scan_top.sv
// Top level of the bitmap first-set/first-clear scanner.
//
// Input channel (in_valid/in_stall) carries one item per transfer: func 0
// writes word_data into bitmap word word_index, func 1 and 2 scan the range
// start_bit .. start_bit+scan_length-1 for the first set or clear bit,
// func 3 does nothing. Each scan yields one result transfer on the output
// channel (out_valid/out_stall) with found and bit_position.
// A write or no-op keeps the controller idle. A scan goes through start-offset
// division (plus a remainder step when WORD_BITS is not a power of two),
// setup, and the scan state, reading one bitmap word per cycle from the RAM
// read port (up to WORDS words) until a hit or the last word, then output.
// An empty range or a start past the bitmap goes straight to output.
// One item is worked at a time; the next is taken once the result sits in
// the output register, even while the receiver stalls it.
// After reset the bitmap is zeroed by a clearing pass over all WORDS words during
// which in_stall is high. A stalled result holds until taken; a scan that
// finishes meanwhile waits in the controller.
`timescale 1ns / 1ps
module bitmap_first_set_or_clear_scan_top #(
  parameter int WORDS     = 64,
  parameter int WORD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bfs_pkg::FUNC_W-1:0]    func,
  input  logic [bfs_pkg::INDEX_W-1:0]   word_index,
  input  logic [bfs_pkg::DATA_W-1:0]    word_data,
  input  logic [bfs_pkg::START_W-1:0]   start_bit,
  input  logic [bfs_pkg::LEN_W-1:0]     scan_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [bfs_pkg::POS_W-1:0]     bit_position
);
  import bfs_pkg::*;

  scan_cmd_t cmd;
  scan_sts_t sts;

  bfs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  bfs_datapath #(
    .WORDS     (WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .func         (func),
    .word_index   (word_index),
    .word_data    (word_data),
    .start_bit    (start_bit),
    .scan_length  (scan_length),
    .found        (found),
    .bit_position (bit_position)
  );

endmodule

FILE: rtl/core/bfs_ram.sv
// Generic single-port-write RAM with registered read.
`timescale 1ns / 1ps
module bfs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/bfs_datapath.sv
// Datapath: bitmap RAM, start-offset divider, word scan and result registers.
`timescale 1ns / 1ps
module bfs_datapath #(
  parameter int WORDS     = 64,
  parameter int WORD_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bfs_pkg::scan_cmd_t            cmd,
  output bfs_pkg::scan_sts_t            sts,
  input  logic [bfs_pkg::FUNC_W-1:0]    func,
  input  logic [bfs_pkg::INDEX_W-1:0]   word_index,
  input  logic [bfs_pkg::DATA_W-1:0]    word_data,
  input  logic [bfs_pkg::START_W-1:0]   start_bit,
  input  logic [bfs_pkg::LEN_W-1:0]     scan_length,
  output logic                          found,
  output logic [bfs_pkg::POS_W-1:0]     bit_position
);
  import bfs_pkg::*;

  localparam int TOT    = WORDS * WORD_BITS;
  localparam int AW     = ($clog2(TOT) > 13) ? $clog2(TOT) + 1 : 14;
  localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int OFS_W  = $clog2(WORD_BITS);
  localparam int CNT_W  = $clog2(START_W + 1);
  localparam int CW     = ($clog2(WORDS + 1) > INDEX_W) ? $clog2(WORDS + 1) : INDEX_W;
  localparam bit POW2   = (WORD_BITS & (WORD_BITS - 1)) == 0;
  // Reciprocal of WORD_BITS, exact floor quotient for every START_W-bit start
  localparam int RS     = START_W + OFS_W;
  localparam int PW     = START_W + RS + 1;
  localparam logic [PW-1:0]     RECIP  = PW'((2 ** RS + WORD_BITS - 1) / WORD_BITS);
  localparam logic [AW-1:0]     TOT_A  = AW'(TOT);
  localparam logic [AW-1:0]     LAST_A = AW'(TOT - 1);
  localparam logic [AW-1:0]     WB_A   = AW'(WORD_BITS);
  localparam logic [OFS_W-1:0]  TOP_O  = OFS_W'(WORD_BITS - 1);
  localparam logic [CW-1:0]     WORDS_C = CW'(WORDS);

  // Clearing pass counter
  logic [WIDX_W-1:0] clr_cnt;

  // Divider
  logic [START_W-1:0] div_q;
  logic [OFS_W-1:0]   div_r;
  logic [CNT_W-1:0]   div_cnt;
  logic [PW-1:0]      recip_prod;

  // Scan state
  logic                 find_clear;
  logic [START_W-1:0]   start_q;
  logic [AW-1:0]        end_pos;
  logic [AW-1:0]        base;
  logic [AW-1:0]        hi_cnt;
  logic [WIDX_W-1:0]    rd_w;
  logic                 first;
  logic                 res_found;
  logic [POS_W-1:0]     res_pos;

  // RAM ports
  logic                 ram_we;
  logic [WIDX_W-1:0]    ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WIDX_W-1:0]    ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // Word evaluation
  logic [AW-1:0]        sum_end;
  logic [WORD_BITS-1:0] word_v;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] hit_v;
  logic [OFS_W-1:0]     hit_idx;
  logic [AW-1:0]        hit_pos;
  logic                 last_word;

  bfs_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_we    = cmd.clear_step || (cmd.write && (CW'(word_index) < WORDS_C));
  assign ram_waddr = cmd.clear_step ? clr_cnt : WIDX_W'(word_index);
  assign ram_wdata = cmd.clear_step ? '0 : word_data[WORD_BITS-1:0];
  assign ram_raddr = cmd.setup ? div_q[WIDX_W-1:0] : rd_w;

  assign sum_end = AW'(start_bit) + AW'(scan_length) - AW'(1);

  assign recip_prod = PW'(start_bit) * RECIP;

  always_comb begin
    word_v    = ram_rdata ^ {WORD_BITS{find_clear}};
    last_word = hi_cnt < WB_A;
    lo_mask   = first ? ({WORD_BITS{1'b1}} << div_r) : {WORD_BITS{1'b1}};
    hi_mask   = last_word ? ({WORD_BITS{1'b1}} >> (TOP_O - hi_cnt[OFS_W-1:0]))
                          : {WORD_BITS{1'b1}};
    hit_v     = word_v & lo_mask & hi_mask;
    hit_idx   = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (hit_v[i]) begin
        hit_idx = OFS_W'(i);
      end
    end
    hit_pos = base + AW'(hit_idx);
  end

  assign sts.clear_last = clr_cnt == WIDX_W'(WORDS - 1);
  assign sts.empty      = (scan_length == '0) || (AW'(start_bit) >= TOT_A);
  assign sts.div_done   = div_cnt == '0;
  assign sts.hit        = |hit_v;
  assign sts.last_word  = last_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + WIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      find_clear <= func_t'(func) == FUNC_SCAN_CLEAR;
      start_q    <= start_bit;
      end_pos    <= (sum_end >= TOT_A) ? LAST_A : sum_end;
      res_found  <= 1'b0;
      res_pos    <= '0;
      if (POW2) begin
        div_q   <= start_bit >> OFS_W;
        div_r   <= start_bit[OFS_W-1:0];
        div_cnt <= '0;
      end else begin
        div_q   <= START_W'(recip_prod >> RS);
        div_r   <= '0;
        div_cnt <= CNT_W'(1);
      end
    end
    if (cmd.div_step) begin
      div_r   <= OFS_W'(AW'(start_q) - AW'(div_q) * WB_A);
      div_cnt <= div_cnt - CNT_W'(1);
    end
    if (cmd.setup) begin
      base   <= AW'(start_q) - AW'(div_r);
      hi_cnt <= end_pos - AW'(start_q) + AW'(div_r);
      rd_w   <= div_q[WIDX_W-1:0] + WIDX_W'(1);
      first  <= 1'b1;
    end
    if (cmd.scan) begin
      base   <= base + WB_A;
      hi_cnt <= hi_cnt - WB_A;
      rd_w   <= rd_w + WIDX_W'(1);
      first  <= 1'b0;
      if (|hit_v) begin
        res_found <= 1'b1;
        res_pos   <= hit_pos[POS_W-1:0];
      end
    end
    if (cmd.publish) begin
      found        <= res_found;
      bit_position <= res_pos;
    end
  end

endmodule

FILE: rtl/core/bfs_ctrl.sv
// Controller: state machine sequencing clear, write, divide, scan and output.
`timescale 1ns / 1ps
module bfs_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [bfs_pkg::FUNC_W-1:0]  func,
  output logic                        out_valid,
  input  logic                        out_stall,
  output bfs_pkg::scan_cmd_t          cmd,
  input  bfs_pkg::scan_sts_t          sts
);
  import bfs_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign in_stall = state != ST_IDLE;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (func_t'(func))
            FUNC_WRITE: begin
              cmd.write = 1'b1;
            end
            FUNC_SCAN_SET, FUNC_SCAN_CLEAR: begin
              cmd.load   = 1'b1;
              state_next = sts.empty ? ST_DONE : ST_DIV;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (sts.div_done) begin
          state_next = ST_SETUP;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.hit || sts.last_word) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/bfs_checker.sv
// Port-level checker for the scanner top level, with its bind.
`timescale 1ns / 1ps
module bfs_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [bfs_pkg::FUNC_W-1:0]    func,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          found,
  input logic [bfs_pkg::POS_W-1:0]     bit_position
);
  import bfs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(found) && $stable(bit_position))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> bit_position == '0)
    else $error("miss with nonzero position");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input open during clearing pass");

  a_write_one: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func == FUNC_WRITE |=> !in_stall)
    else $error("write transfer blocked the input");

  a_scan_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (func == FUNC_SCAN_SET || func == FUNC_SCAN_CLEAR)
    |=> in_stall)
    else $error("scan transfer did not occupy the block");

endmodule

bind bitmap_first_set_or_clear_scan_top bfs_checker u_bfs_checker (.*);

FILE: bench/testbench.sv
// Self-checking testbench for the bitmap first-set/first-clear scanner.
`timescale 1ns / 1ps

typedef struct packed {
  logic       found;
  logic [11:0] pos;
} scan_hit_t;

class scan_scoreboard;
  localparam int WORDS     = 64;
  localparam int WORD_BITS = 64;
  localparam int TOTAL     = WORDS * WORD_BITS;

  logic [WORD_BITS-1:0] bitmap_q [WORDS];
  scan_hit_t            pending_hits [$];
  int                   errors;

  function new();
    foreach (bitmap_q[i]) bitmap_q[i] = '0;
    errors = 0;
  endfunction

  // Lowest matching bit in start .. start+len-1, range end clamped to the bitmap.
  function scan_hit_t first_hit(bfs_pkg::func_t f, logic [11:0] start, logic [12:0] len);
    scan_hit_t            hit;
    int                   last_bit;
    int                   w;
    logic [WORD_BITS-1:0] v;
    hit = '0;
    if (len == 0) return hit;
    last_bit = int'(start) + int'(len) - 1;
    if (last_bit > TOTAL - 1) last_bit = TOTAL - 1;
    for (w = int'(start) / WORD_BITS; w <= last_bit / WORD_BITS && !hit.found; w++) begin
      v = (f == bfs_pkg::FUNC_SCAN_CLEAR) ? ~bitmap_q[w] : bitmap_q[w];
      if (w == int'(start) / WORD_BITS) v &= {WORD_BITS{1'b1}} << (int'(start) % WORD_BITS);
      if (w == last_bit / WORD_BITS) v &= {WORD_BITS{1'b1}} >> (63 - last_bit % WORD_BITS);
      for (int b = 0; b < WORD_BITS && !hit.found; b++) begin
        if (v[b]) begin
          hit.found = 1'b1;
          hit.pos   = 12'(w * WORD_BITS + b);
        end
      end
    end
    return hit;
  endfunction

  function void record_input(bfs_pkg::func_t f, logic [5:0] idx, logic [63:0] data,
                             logic [11:0] start, logic [12:0] len);
    case (f)
      bfs_pkg::FUNC_WRITE: begin
        if (int'(idx) < WORDS) bitmap_q[idx] = data[WORD_BITS-1:0];
      end
      bfs_pkg::FUNC_SCAN_SET, bfs_pkg::FUNC_SCAN_CLEAR: begin
        pending_hits.push_back(first_hit(f, start, len));
      end
      default: ;
    endcase
  endfunction

  function void check_result(logic found, logic [11:0] pos);
    scan_hit_t want;
    if (pending_hits.size() == 0) begin
      $display("%0t: unexpected result transfer, found %0b position %0d", $time, found, pos);
      errors++;
      return;
    end
    want = pending_hits.pop_front();
    if (found !== want.found) begin
      $display("%0t: found mismatch, expected %0b, actual %0b", $time, want.found, found);
      errors++;
    end
    if (pos !== want.pos) begin
      $display("%0t: bit_position mismatch, expected %0d, actual %0d", $time, want.pos, pos);
      errors++;
    end
  endfunction

  function int pending();
    return pending_hits.size();
  endfunction
endclass

module testbench;
  import bfs_pkg::*;

  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 1230;
  localparam int LONG_HOLD    = 300;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [FUNC_W-1:0]    func;
  logic [INDEX_W-1:0]   word_index;
  logic [DATA_W-1:0]    word_data;
  logic [START_W-1:0]   start_bit;
  logic [LEN_W-1:0]     scan_length;
  logic                 out_valid;
  logic                 out_stall;
  logic                 found;
  logic [POS_W-1:0]     bit_position;

  scan_scoreboard sb = new();
  int burst_left;

  bitmap_first_set_or_clear_scan_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .word_index   (word_index),
    .word_data    (word_data),
    .start_bit    (start_bit),
    .scan_length  (scan_length),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .found        (found),
    .bit_position (bit_position)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one item and hold it until the transfer happens.
  task automatic send_item(func_t f, logic [5:0] idx, logic [63:0] data,
                           logic [11:0] start, logic [12:0] len);
    in_valid    <= 1'b1;
    func        <= f;
    word_index  <= idx;
    word_data   <= data;
    start_bit   <= start;
    scan_length <= len;
    do @(posedge clk); while (in_stall);
    sb.record_input(f, idx, data, start, len);
  endtask

  // Sender bursts with random gaps in between.
  task automatic pace();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 20);
      case ($urandom_range(0, 7))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 8);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send(func_t f, logic [5:0] idx, logic [63:0] data,
                      logic [11:0] start, logic [12:0] len);
    send_item(f, idx, data, start, len);
    pace();
  endtask

  function automatic logic [63:0] make_word();
    logic [63:0] a, b, c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      3:       return ~(64'd1 << $urandom_range(0, 63));
      4:       return a & b & c;
      5:       return a | b | c;
      default: return a;
    endcase
  endfunction

  function automatic logic [11:0] make_start();
    case ($urandom_range(0, 5))
      0:       return {6'($urandom), 6'd0};
      1:       return {6'($urandom), 6'd63};
      2:       return 12'(3968 + $urandom_range(0, 127));
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [12:0] make_length(logic [11:0] start);
    case ($urandom_range(0, 9))
      0:          return 13'($urandom_range(0, 1));
      1, 2, 3, 4: return 13'($urandom_range(1, 128));
      5, 6:       return 13'($urandom_range(1, 4096));
      7:          return 13'($urandom_range(4097, 8191));
      8:          return 13'(64 * $urandom_range(1, 8));
      default:    return 13'(4096 - int'(start) + $urandom_range(0, 2) - 1);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(found, bit_position);
  end

  // Receiver stall pattern, with a long hold-off to back the block up.
  initial begin
    int seg;
    int n;
    int mode;
    out_stall <= 1'b0;
    seg = 0;
    repeat (12) @(posedge clk);
    forever begin
      seg++;
      mode = (seg == 4 || $urandom_range(0, 39) == 0) ? 0 : $urandom_range(1, 3);
      n = (mode == 0) ? LONG_HOLD : $urandom_range(5, 60);
      for (int i = 0; i < n; i++) begin
        case (mode)
          0:       out_stall <= 1'b1;
          1:       out_stall <= 1'b0;
          2:       out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    repeat (10) @(posedge clk);
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int          sent;
    int          r;
    logic [11:0] start;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    func        <= FUNC_NOP;
    word_index  <= '0;
    word_data   <= '0;
    start_bit   <= '0;
    scan_length <= '0;
    burst_left  = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: empty bitmap, extremes, clamping, range-end and empty-range cases
    send(FUNC_SCAN_SET,   6'd0,  '0, 12'd0,    13'd4096);
    send(FUNC_SCAN_CLEAR, 6'd0,  '0, 12'd0,    13'd1);
    send(FUNC_SCAN_SET,   6'd0,  '0, 12'd100,  13'd0);
    send(FUNC_WRITE,      6'd5,  64'h8000_0000_0000_0000, '0, '0);
    send(FUNC_WRITE,      6'd10, 64'd1, '0, '0);
    send(FUNC_WRITE,      6'd63, '1, '0, '0);
    send(FUNC_NOP,        6'd1,  '1, 12'd0,    13'd4096);
    send(FUNC_SCAN_SET,   6'd0,  '0, 12'd0,    13'd4096);
    send(FUNC_SCAN_SET,   6'd0,  '0, 12'd384,  13'd256);
    send(FUNC_SCAN_SET,   6'd0,  '0, 12'd384,  13'd257);
    send(FUNC_SCAN_SET,   6'd0,  '0, 12'd320,  13'd63);
    send(FUNC_SCAN_SET,   6'd0,  '0, 12'd383,  13'd1);
    send(FUNC_SCAN_CLEAR, 6'd0,  '0, 12'd4032, 13'd64);
    send(FUNC_SCAN_CLEAR, 6'd0,  '0, 12'd4095, 13'd1);
    send(FUNC_SCAN_SET,   6'd0,  '0, 12'd4095, 13'd8191);
    send(FUNC_WRITE,      6'd0,  '1, '0, '0);
    send(FUNC_SCAN_CLEAR, 6'd0,  '0, 12'd0,    13'd4096);
    send(FUNC_WRITE,      6'd63, '0, '0, '0);
    send(FUNC_SCAN_SET,   6'd0,  '0, 12'd4000, 13'd8191);
    send(FUNC_SCAN_CLEAR, 6'd0,  '0, 12'd4095, 13'd8191);
    send(FUNC_WRITE,      6'd63, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0);
    send(FUNC_SCAN_CLEAR, 6'd0,  '0, 12'd4032, 13'd4096);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 19);
      start = make_start();
      if (r == 0) begin
        send(FUNC_NOP, 6'($urandom), make_word(), start, 13'($urandom));
      end else if (r <= 7) begin
        send(FUNC_WRITE, 6'($urandom), make_word(), start, 13'($urandom));
        sent++;
      end else begin
        send((r <= 13) ? FUNC_SCAN_SET : FUNC_SCAN_CLEAR, 6'($urandom),
             {$urandom, $urandom}, start, make_length(start));
        sent++;
      end
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/core/bfs_pkg.sv
rtl/core/bfs_ram.sv
rtl/core/bfs_datapath.sv
rtl/core/bfs_ctrl.sv
rtl/core/bitmap_first_set_or_clear_scan_top.sv
rtl/core/bfs_checker.sv
bench/testbench.sv
